/* hw/rtl/esr_pkg.sv */
// ----------------------------------------------------------------------------
// esr_pkg
// Shared types and constants for the ellipse span rasterizer.
// ----------------------------------------------------------------------------
package esr_pkg;

    localparam int CORNER_W       = 10;
    localparam int FILL_W         = 8;
    localparam int OUT_COORD_W    = 12;
    localparam int OUT_WIDTH_W    = 11;
    localparam int COORD_BITS_DEF = 10;

    localparam int CQ_DEPTH = 4;
    localparam int CQ_AW    = 2;

    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    typedef struct packed {
        logic                op;
        logic [CORNER_W-1:0] corner_ax;
        logic [CORNER_W-1:0] corner_ay;
        logic [CORNER_W-1:0] corner_bx;
        logic [CORNER_W-1:0] corner_by;
        logic [FILL_W-1:0]   fill_value;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_COORD_W-1:0] span_x;
        logic signed [OUT_COORD_W-1:0] span_y;
        logic [OUT_WIDTH_W-1:0]        span_width;
        logic [FILL_W-1:0]             paint_value;
        logic                          last;
        logic                          done_res;
    } t_out_item;

    // Classified command between front end and stepping engine
    typedef struct packed {
        logic                is_start;
        logic [CORNER_W-1:0] min_x;
        logic [CORNER_W-1:0] min_y;
        logic [CORNER_W-1:0] dx;
        logic [CORNER_W-1:0] dy;
        logic [FILL_W-1:0]   fill;
    } t_cmd;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_MAIN,
        PH_TIP
    } t_phase;

    typedef enum logic [3:0] {
        ST_WAIT,
        ST_MUL1,
        ST_MUL2,
        ST_SUM,
        ST_ADV1,
        ST_ADV2,
        ST_ADV3,
        ST_ADV4,
        ST_TIP,
        ST_EMIT
    } t_seq_state;

endpackage

/* hw/rtl/esr_front.sv */
// ----------------------------------------------------------------------------
// esr_front
// Input stage: masks corners, classifies the item and forms the bounding
// box extents for the command queue.
// ----------------------------------------------------------------------------
module esr_front import esr_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic     i_push,
    input  t_in_item i_item,
    input  logic     i_full,
    output logic     o_push,
    output t_cmd     o_cmd
);

    localparam logic [CORNER_W-1:0] CMASK = CORNER_W'((64'd1 << COORD_BITS) - 64'd1);

    logic [CORNER_W-1:0] ax;
    logic [CORNER_W-1:0] ay;
    logic [CORNER_W-1:0] bx;
    logic [CORNER_W-1:0] by;

    always_comb begin
        ax = i_item.corner_ax & CMASK;
        ay = i_item.corner_ay & CMASK;
        bx = i_item.corner_bx & CMASK;
        by = i_item.corner_by & CMASK;

        o_cmd.is_start = (i_item.op == OP_START);
        o_cmd.min_x    = (ax < bx) ? ax : bx;
        o_cmd.min_y    = (ay < by) ? ay : by;
        o_cmd.dx       = (ax > bx) ? (ax - bx) : (bx - ax);
        o_cmd.dy       = (ay > by) ? (ay - by) : (by - ay);
        o_cmd.fill     = i_item.fill_value;
    end

    assign o_push = i_push && !i_full;

endmodule

/* hw/rtl/esr_cmd_queue.sv */
// ----------------------------------------------------------------------------
// esr_cmd_queue
// Short command queue decoupling the front end from the stepping engine.
// ----------------------------------------------------------------------------
module esr_cmd_queue import esr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam logic [CQ_AW:0] DEPTH_C = (CQ_AW + 1)'(CQ_DEPTH);

    t_cmd             r_mem [CQ_DEPTH];
    logic [CQ_AW-1:0] r_wr_ptr;
    logic [CQ_AW-1:0] r_rd_ptr;
    logic [CQ_AW:0]   r_count;
    logic [CQ_AW:0]   n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_full  = (r_count == DEPTH_C);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

endmodule

/* hw/rtl/esr_engine.sv */
// ----------------------------------------------------------------------------
// esr_engine
// Stepping engine: error-term setup, Bresenham steps and result emission
// through a one-entry output register.
// ----------------------------------------------------------------------------
module esr_engine import esr_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_pop,
    output logic      o_res_valid,
    output t_out_item o_res,
    input  logic      i_res_pop
);

    localparam int HW = COORD_BITS;
    localparam int CW = COORD_BITS + 2;
    localparam int MW = 2 * COORD_BITS;
    localparam int PW = 3 * COORD_BITS + 2;
    localparam int EW = 3 * COORD_BITS + 8;

    localparam logic [1:0] LAST_MAIN = 2'd1;
    localparam logic [1:0] LAST_TIP  = 2'd3;

    t_seq_state r_state;
    t_seq_state n_state;
    t_phase     r_phase;

    logic signed [CW-1:0] r_left;
    logic signed [CW-1:0] r_right;
    logic signed [CW-1:0] r_lower;
    logic signed [CW-1:0] r_upper;
    logic [HW-1:0]        r_height;
    logic [HW-1:0]        r_a;
    logic                 r_odd;
    logic signed [HW:0]   r_oma;
    logic [MW-1:0]        r_aa;
    logic [MW-1:0]        r_bb;
    logic signed [EW-1:0] r_step_a;
    logic signed [EW-1:0] r_step_b;
    logic signed [EW-1:0] r_err_x;
    logic signed [EW-1:0] r_err_y;
    logic signed [EW-1:0] r_err_total;
    logic signed [EW-1:0] r_ey_part;
    logic signed [EW-1:0] r_e2;
    logic                 r_c1;
    logic                 r_c2;
    logic [FILL_W-1:0]    r_held;

    logic signed [CW-1:0]   r_x0;
    logic signed [CW-1:0]   r_x1;
    logic signed [CW-1:0]   r_r0;
    logic signed [CW-1:0]   r_r1;
    logic [OUT_WIDTH_W-1:0] r_w;
    logic                   r_tip;
    logic                   r_fin;
    logic [1:0]             r_cnt;

    logic      r_out_valid;
    t_out_item r_out;

    logic [HW-1:0]        cmd_a;
    logic [HW-1:0]        cmd_b;
    logic [HW:0]          b_inc;
    logic signed [PW-1:0] prod;
    logic signed [EW-1:0] aa_ext;
    logic signed [EW-1:0] ey0;
    logic signed [EW-1:0] tot2;
    logic                 c1;
    logic                 c2;
    logic signed [CW-1:0] row_diff;
    logic signed [CW-1:0] height_s;
    logic                 emit_last;
    logic                 out_load;
    logic                 cmd_pop;
    t_out_item            emit_item;

    // ---------------- datapath helpers
    always_comb begin
        cmd_a    = HW'(i_cmd.dx);
        cmd_b    = HW'(i_cmd.dy);
        b_inc    = {1'b0, cmd_b} + (HW + 1)'(1);
        prod     = r_oma * $signed({1'b0, r_bb});
        aa_ext   = $signed(EW'(r_aa));
        ey0      = r_odd ? (aa_ext <<< 3) : (aa_ext <<< 2);
        tot2     = r_err_total <<< 1;
        c1       = (tot2 <= r_err_y);
        c2       = (r_e2 >= r_err_x) || (tot2 > r_err_y);
        row_diff = r_lower - r_upper;
        height_s = $signed({2'b00, r_height});
    end

    always_comb begin
        emit_item.span_x      = OUT_COORD_W'((r_tip && r_cnt[0]) ? r_x1 : r_x0);
        emit_item.span_y      = OUT_COORD_W'((r_tip ? r_cnt[1] : r_cnt[0]) ? r_r1 : r_r0);
        emit_item.span_width  = r_w;
        emit_item.paint_value = r_held;
        emit_item.last        = emit_last;
        emit_item.done_res    = emit_last && r_fin;
    end

    assign emit_last = (r_cnt == (r_tip ? LAST_TIP : LAST_MAIN));

    // ---------------- sequencer: next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_WAIT: begin
                if (i_cmd_valid) begin
                    if (i_cmd.is_start) begin
                        n_state = ST_MUL1;
                    end else if (r_phase == PH_MAIN) begin
                        n_state = ST_ADV1;
                    end else if (r_phase == PH_TIP) begin
                        n_state = ST_TIP;
                    end
                end
            end
            ST_MUL1: n_state = ST_MUL2;
            ST_MUL2: n_state = ST_SUM;
            ST_SUM:  n_state = ST_WAIT;
            ST_ADV1: n_state = ST_ADV2;
            ST_ADV2: n_state = ST_ADV3;
            ST_ADV3: n_state = ST_ADV4;
            ST_ADV4: n_state = ST_EMIT;
            ST_TIP:  n_state = ST_EMIT;
            ST_EMIT: begin
                if (out_load && emit_last) begin
                    n_state = ST_WAIT;
                end
            end
            default: n_state = ST_WAIT;
        endcase
    end

    // ---------------- sequencer: outputs
    always_comb begin
        cmd_pop  = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            ST_WAIT: cmd_pop  = i_cmd_valid;
            ST_EMIT: out_load = !r_out_valid || i_res_pop;
            default: begin
                cmd_pop  = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_WAIT;
            r_phase     <= PH_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_cnt       <= emit_last ? 2'd0 : (r_cnt + 1'b1);
            end else if (i_res_pop) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ST_SUM) begin
                r_phase <= PH_MAIN;
            end else if (r_state == ST_ADV4 && r_right < r_left) begin
                r_phase <= (row_diff < height_s) ? PH_TIP : PH_IDLE;
            end else if (r_state == ST_TIP && !((row_diff + CW'(2)) < height_s)) begin
                r_phase <= PH_IDLE;
            end
        end
    end

    // ---------------- datapath
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= emit_item;
        end
        case (r_state)
            ST_WAIT: begin
                if (cmd_pop && i_cmd.is_start) begin
                    r_left   <= $signed(CW'(i_cmd.min_x));
                    r_right  <= $signed(CW'(i_cmd.min_x)) + $signed(CW'(cmd_a));
                    r_lower  <= $signed(CW'(i_cmd.min_y)) + $signed({2'b00, b_inc[HW:1]});
                    r_a      <= cmd_a;
                    r_height <= cmd_b;
                    r_odd    <= cmd_b[0];
                    r_held   <= i_cmd.fill;
                end
            end
            ST_MUL1: begin
                r_aa    <= r_a * r_a;
                r_bb    <= r_height * r_height;
                r_oma   <= $signed((HW + 1)'(1) - {1'b0, r_a});
                r_upper <= r_lower - $signed(CW'(r_odd));
            end
            ST_MUL2: begin
                r_err_x   <= $signed(EW'(prod)) <<< 2;
                r_err_y   <= ey0;
                r_ey_part <= ey0 + (r_odd ? aa_ext : '0);
                r_step_a  <= aa_ext <<< 3;
                r_step_b  <= $signed(EW'(r_bb)) <<< 3;
            end
            ST_SUM: begin
                r_err_total <= r_err_x + r_ey_part;
            end
            ST_ADV1: begin
                r_x0 <= r_left;
                r_r0 <= r_lower;
                r_r1 <= r_upper;
                r_w  <= OUT_WIDTH_W'(r_right - r_left);
                r_tip <= 1'b0;
                r_e2 <= tot2;
                r_c1 <= c1;
                if (c1) begin
                    r_err_y <= r_err_y + r_step_a;
                    r_lower <= r_lower + 1'b1;
                    r_upper <= r_upper - 1'b1;
                end
            end
            ST_ADV2: begin
                if (r_c1) begin
                    r_err_total <= r_err_total + r_err_y;
                end
            end
            ST_ADV3: begin
                r_c2 <= c2;
                if (c2) begin
                    r_left  <= r_left + 1'b1;
                    r_right <= r_right - 1'b1;
                    r_err_x <= r_err_x + r_step_b;
                end
            end
            ST_ADV4: begin
                if (r_c2) begin
                    r_err_total <= r_err_total + r_err_x;
                end
                r_fin <= (r_right < r_left) && !(row_diff < height_s);
            end
            ST_TIP: begin
                r_x0    <= r_left - 1'b1;
                r_x1    <= r_right + 1'b1;
                r_r0    <= r_lower;
                r_r1    <= r_upper;
                r_w     <= OUT_WIDTH_W'(1);
                r_tip   <= 1'b1;
                r_fin   <= !((row_diff + CW'(2)) < height_s);
                r_lower <= r_lower + 1'b1;
                r_upper <= r_upper - 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_cmd_pop   = cmd_pop;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

/* hw/rtl/ellipse_span_rasterizer.sv */
// ----------------------------------------------------------------------------
// ellipse_span_rasterizer
// Rectangle-bounded Bresenham ellipse emitted as horizontal spans.
// ----------------------------------------------------------------------------
// A start item (op 0) gives no result; the engine dequeues it and latches
// the box, squares both extents, forms the products and sums the error term.
// An advance item in the main phase is dequeued, then updates the error terms
// (two dependent wide add/compare pairs per axis) and gives 2 spans, one per
// cycle while the output is not held. In the tip phase it is dequeued, updates
// the rows and then gives 4 pixels, one per cycle while the output is not
// held. An advance while no figure is active is dropped. Results leave one
// per cycle through a single output register; a result that is not popped
// holds the engine. A 4-deep command queue behind the input stage keeps
// accepting items while the engine works, until the queue is full.
// ----------------------------------------------------------------------------
module ellipse_span_rasterizer import esr_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_in_item  i_item,
    output logic      o_full,
    input  logic      i_pop,
    output logic      o_empty,
    output t_out_item o_res
);

    logic front_push;
    t_cmd front_cmd;
    logic cmd_valid;
    t_cmd cmd;
    logic cmd_pop;
    logic res_valid;

    esr_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .i_push (i_push),
        .i_item (i_item),
        .i_full (o_full),
        .o_push (front_push),
        .o_cmd  (front_cmd)
    );

    esr_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .o_full  (o_full),
        .i_pop   (cmd_pop),
        .o_valid (cmd_valid),
        .o_cmd   (cmd)
    );

    esr_engine #(
        .COORD_BITS(COORD_BITS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_res_valid (res_valid),
        .o_res       (o_res),
        .i_res_pop   (i_pop)
    );

    assign o_empty = !res_valid;

    a_pop_needs_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command popped from empty queue");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_res.done_res) |-> o_res.last)
        else $error("done without last");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> o_empty)
        else $error("result pending after reset");

endmodule

/* test/tb_ellipse_span_rasterizer.sv */
// ----------------------------------------------------------------------------
// tb_ellipse_span_rasterizer
// Self-checking bench for the rectangle-bounded ellipse span rasterizer.
// ----------------------------------------------------------------------------
// Start and advance items go in through the push/full queue port with random
// gaps. Each accepted item runs through an in-bench model of the stepping
// logic, which queues the spans and tip pixels it should give. Results are
// popped with random stalls and checked field by field, oldest first.
// Directed figures cover the corner extremes, abandoned figures, advances
// while idle, degenerate boxes and flat and tall ellipses that need the tip
// phase. The random part is mostly whole figures of random size and
// position, with some noise items and some figures cut short by a new start.
// ----------------------------------------------------------------------------
module tb_ellipse_span_rasterizer import esr_pkg::*; ;

    localparam int TARGET_ITEMS    = 480;
    localparam int MAX_GAP         = 14;
    localparam int HOLD_OFF_AT     = 60;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 50;
    localparam int COORD_MAX       = (1 << CORNER_W) - 1;

    class span_tracker;
        int                left_x, right_x, lower_row, upper_row, height_span;
        longint            step_a, step_b, err_x, err_y, err_total;
        t_phase            phase;
        logic [FILL_W-1:0] held_value;
        t_out_item         spans_due[$];
        int                err_count;

        function void clear();
            left_x      = 0;
            right_x     = 0;
            lower_row   = 0;
            upper_row   = 0;
            height_span = 0;
            step_a      = 0;
            step_b      = 0;
            err_x       = 0;
            err_y       = 0;
            err_total   = 0;
            phase       = PH_IDLE;
            held_value  = '0;
            err_count   = 0;
            spans_due.delete();
        endfunction

        function void queue_span(int x, int y, int w, bit lst, bit dn);
            t_out_item r;
            r.span_x      = x[OUT_COORD_W-1:0];
            r.span_y      = y[OUT_COORD_W-1:0];
            r.span_width  = w[OUT_WIDTH_W-1:0];
            r.paint_value = held_value;
            r.last        = lst;
            r.done_res    = dn;
            spans_due.push_back(r);
        endfunction

        function void note_item(t_in_item it);
            int     cmask, ax, ay, bx, by, ymin, x, w, r0, r1;
            longint a, b, odd, e2;
            bit     fin;
            cmask = (1 << COORD_BITS_DEF) - 1;
            fin   = 1'b0;
            if (it.op == OP_START) begin
                ax   = int'(it.corner_ax) & cmask;
                ay   = int'(it.corner_ay) & cmask;
                bx   = int'(it.corner_bx) & cmask;
                by   = int'(it.corner_by) & cmask;
                a    = (ax > bx) ? ax - bx : bx - ax;
                b    = (ay > by) ? ay - by : by - ay;
                odd  = b & 1;
                ymin = (ay < by) ? ay : by;
                err_x       = 4 * (1 - a) * b * b;
                err_y       = 4 * (odd + 1) * a * a;
                err_total   = err_x + err_y + odd * a * a;
                left_x      = (ax < bx) ? ax : bx;
                right_x     = left_x + int'(a);
                lower_row   = ymin + int'((b + 1) / 2);
                upper_row   = lower_row - int'(odd);
                height_span = int'(b);
                step_a      = 8 * a * a;
                step_b      = 8 * b * b;
                held_value  = it.fill_value;
                phase       = PH_MAIN;
            end else if (phase == PH_MAIN) begin
                w  = right_x - left_x;
                r0 = lower_row;
                r1 = upper_row;
                x  = left_x;
                e2 = 2 * err_total;
                if (e2 <= err_y) begin
                    lower_row++;
                    upper_row--;
                    err_y     += step_a;
                    err_total += err_y;
                end
                if (e2 >= err_x || 2 * err_total > err_y) begin
                    left_x++;
                    right_x--;
                    err_x     += step_b;
                    err_total += err_x;
                end
                if (left_x > right_x) begin
                    if (lower_row - upper_row < height_span) begin
                        phase = PH_TIP;
                    end else begin
                        phase = PH_IDLE;
                        fin   = 1'b1;
                    end
                end
                queue_span(x, r0, w, 1'b0, 1'b0);
                queue_span(x, r1, w, 1'b1, fin);
            end else if (phase == PH_TIP) begin
                r0 = lower_row;
                r1 = upper_row;
                lower_row++;
                upper_row--;
                fin = !(lower_row - upper_row < height_span);
                if (fin) begin
                    phase = PH_IDLE;
                end
                queue_span(left_x - 1, r0, 1, 1'b0, 1'b0);
                queue_span(right_x + 1, r0, 1, 1'b0, 1'b0);
                queue_span(left_x - 1, r1, 1, 1'b0, 1'b0);
                queue_span(right_x + 1, r1, 1, 1'b1, fin);
            end
        endfunction

        function void compare_field(string name, logic signed [15:0] want,
                                    logic signed [15:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                err_count++;
            end
        endfunction

        function void check_span(t_out_item got);
            t_out_item want;
            if (spans_due.size() == 0) begin
                $error("unexpected result: x %0d y %0d width %0d",
                       got.span_x, got.span_y, got.span_width);
                err_count++;
                return;
            end
            want = spans_due.pop_front();
            compare_field("span_x", 16'(want.span_x), 16'(got.span_x));
            compare_field("span_y", 16'(want.span_y), 16'(got.span_y));
            compare_field("span_width", 16'(want.span_width), 16'(got.span_width));
            compare_field("paint_value", 16'(want.paint_value), 16'(got.paint_value));
            compare_field("last", 16'(want.last), 16'(got.last));
            compare_field("done_res", 16'(want.done_res), 16'(got.done_res));
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_push;
    t_in_item  i_item;
    logic      o_full;
    logic      i_pop;
    logic      o_empty;
    t_out_item o_res;

    span_tracker sb;
    int          accepted_items = 0;
    int          send_calm = 0;

    ellipse_span_rasterizer uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_item  (i_item),
        .o_full  (o_full),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_res   (o_res)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_in_item random_item();
        t_in_item it;
        it.op         = 1'($urandom_range(0, 1));
        it.corner_ax  = CORNER_W'($urandom_range(0, COORD_MAX));
        it.corner_ay  = CORNER_W'($urandom_range(0, COORD_MAX));
        it.corner_bx  = CORNER_W'($urandom_range(0, COORD_MAX));
        it.corner_by  = CORNER_W'($urandom_range(0, COORD_MAX));
        it.fill_value = FILL_W'($urandom_range(0, 255));
        return it;
    endfunction

    // Leaves push high after the accepting edge; the next call or the
    // caller drives it again at the following falling edge.
    task automatic push_item(t_in_item it);
        int gap;
        if (send_calm > 0) begin
            send_calm--;
            gap = 0;
        end else if ($urandom_range(0, 19) == 0) begin
            send_calm = $urandom_range(10, 40);
            gap = 0;
        end else begin
            gap = $urandom_range(0, MAX_GAP);
        end
        repeat (gap) @(negedge i_clk) i_push <= 1'b0;
        @(negedge i_clk) begin
            i_push <= 1'b1;
            i_item <= it;
        end
        do @(posedge i_clk); while (o_full);
        if (!(it.op == OP_ADVANCE && sb.phase == PH_IDLE)) begin
            accepted_items++;
        end
        sb.note_item(it);
    endtask

    task automatic push_advance();
        t_in_item it;
        it    = random_item();
        it.op = OP_ADVANCE;
        push_item(it);
    endtask

    task automatic run_figure(int ax, int ay, int bx, int by,
                              logic [FILL_W-1:0] fill, int max_steps);
        t_in_item it;
        int       n;
        it            = random_item();
        it.op         = OP_START;
        it.corner_ax  = ax[CORNER_W-1:0];
        it.corner_ay  = ay[CORNER_W-1:0];
        it.corner_bx  = bx[CORNER_W-1:0];
        it.corner_by  = by[CORNER_W-1:0];
        it.fill_value = fill;
        push_item(it);
        n = 0;
        while (sb.phase != PH_IDLE && n < max_steps) begin
            push_advance();
            n++;
        end
    endtask

    initial begin : stimulus
        int  ext, w, h, x0, y0, ax, ay, bx, by, steps;
        bit  drained;
        i_rst_n = 1'b0;
        i_push  = 1'b0;
        i_item  = '0;
        sb = new;
        sb.clear();
        drained = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        push_advance();
        run_figure(0, 0, COORD_MAX, COORD_MAX, 8'hFF, 3);
        run_figure(COORD_MAX, COORD_MAX, 0, 0, 8'h00, 2);
        run_figure(5, 7, 5, 7, 8'h5A, 8);
        push_advance();
        run_figure(11, 4, 3, 3, 8'h33, 16);
        run_figure(3, 3, 4, 12, 8'hC3, 16);
        run_figure(6, 0, 6, 5, 8'h81, 16);

        while (accepted_items < TARGET_ITEMS) begin
            if (!drained && accepted_items >= TARGET_ITEMS / 2) begin
                @(negedge i_clk) i_push <= 1'b0;
                while (sb.spans_due.size() != 0) @(posedge i_clk);
                drained = 1'b1;
            end
            if ($urandom_range(0, 99) < 10) begin
                push_item(random_item());
            end else begin
                ext = $urandom_range(0, 99);
                if (ext < 70) begin
                    ext = 24;
                end else if (ext < 93) begin
                    ext = 120;
                end else begin
                    ext = COORD_MAX;
                end
                w  = $urandom_range(0, ext);
                h  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3)
                                                 : $urandom_range(0, ext);
                x0 = $urandom_range(0, COORD_MAX - w);
                y0 = $urandom_range(0, COORD_MAX - h);
                if ($urandom_range(0, 1)) begin
                    ax = x0;
                    bx = x0 + w;
                end else begin
                    ax = x0 + w;
                    bx = x0;
                end
                if ($urandom_range(0, 1)) begin
                    ay = y0;
                    by = y0 + h;
                end else begin
                    ay = y0 + h;
                    by = y0;
                end
                // big boxes and a few others get cut short by the next start
                steps = (ext == COORD_MAX || $urandom_range(0, 9) == 0)
                        ? $urandom_range(1, 20) : 100000;
                run_figure(ax, ay, bx, by, FILL_W'($urandom_range(0, 255)), steps);
            end
        end
        @(negedge i_clk) i_push <= 1'b0;

        while (sb.spans_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin : result_drain
        int stall, popped, calm_left;
        i_pop     = 1'b0;
        popped    = 0;
        calm_left = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (calm_left > 0) begin
                calm_left--;
                stall = 0;
            end else if ($urandom_range(0, 19) == 0) begin
                calm_left = $urandom_range(10, 40);
                stall = 0;
            end else begin
                stall = $urandom_range(0, MAX_GAP);
            end
            repeat (stall) @(negedge i_clk) i_pop <= 1'b0;
            @(negedge i_clk) i_pop <= 1'b1;
            do @(posedge i_clk); while (o_empty);
            sb.check_span(o_res);
            popped++;
            // long hold-off so the block backs up and stalls its input
            if (popped == HOLD_OFF_AT) begin
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk) i_pop <= 1'b0;
            end
        end
    end

    initial begin : watchdog
        #12000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/esr_pkg.sv
hw/rtl/esr_front.sv
hw/rtl/esr_cmd_queue.sv
hw/rtl/esr_engine.sv
hw/rtl/ellipse_span_rasterizer.sv
test/tb_ellipse_span_rasterizer.sv
